// ===== hdl/rhsv_pkg.sv =====
// Shared types, widths and the divider step for the RGB to HSV converter.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps

package rhsv_pkg;

    localparam int unsigned CompW  = 8;              // width of a color component
    localparam int unsigned QuotW  = 8;              // width of each quotient
    localparam int unsigned DenW   = CompW + 3;      // holds 6 * spread
    localparam int unsigned NumW   = DenW + CompW;   // holds 255 * numerator
    localparam int unsigned QDepth = 2;              // entries in the decoupling queue

    // Partial state of one restoring division.
    typedef struct packed {
        logic [NumW-1:0]  rem;
        logic [DenW-1:0]  den;
        logic [QuotW-1:0] quo;
    } t_div;

    // One classified pixel, ready for the two divisions.
    typedef struct packed {
        t_div             hue;
        t_div             sat;
        logic [CompW-1:0] value;
    } t_work;

    // One restoring step: try to take den shifted by sh from the remainder.
    function automatic t_div div_step(t_div s, int unsigned sh);
        t_div             r;
        logic [NumW-1:0]  trial;
        r     = s;
        trial = NumW'(s.den) << sh;
        if (s.rem >= trial) begin
            r.rem     = s.rem - trial;
            r.quo[sh] = 1'b1;
        end
        return r;
    endfunction

endpackage

// ===== hdl/rhsv_rgb_if.sv =====
// Channel interfaces for RGB requests and HSV results.
// Depends on rhsv_pkg for the component width.
`timescale 1ns / 1ps

interface rhsv_rgb_if;
    logic                          valid;
    logic                          ready;
    logic [rhsv_pkg::CompW-1:0]    red;
    logic [rhsv_pkg::CompW-1:0]    green;
    logic [rhsv_pkg::CompW-1:0]    blue;
    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rhsv_hsv_if;
    logic                          valid;
    logic                          ready;
    logic [rhsv_pkg::QuotW-1:0]    hue;
    logic [rhsv_pkg::QuotW-1:0]    saturation;
    logic [rhsv_pkg::CompW-1:0]    brightness;
    modport source (output valid, hue, saturation, brightness, input ready);
    modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

// ===== hdl/rgb_to_hsv_convert.sv =====
// Top level of the 8-bit RGB to HSV converter.
// Depends on rhsv_pkg, the channel interfaces, rhsv_front, rhsv_queue, rhsv_back.
//
//   Port     Direction  Carries
//   i_pix    in         red, green, blue (8 bits each)
//   o_hsv    out        hue, saturation, brightness (8 bits each)
//
// One pixel is taken every cycle while the output is not stalled. A result
// passes ten registers: the front register, the queue and eight divider
// stages, one quotient bit per stage.
// Reset is synchronous and clears only the valid bits, queue pointers and fill count.
// A stalled output freezes the divider pipeline; the queue and front
// register keep taking requests until they fill.
`timescale 1ns / 1ps

module rgb_to_hsv_convert (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rhsv_rgb_if.sink    i_pix,
    rhsv_hsv_if.source  o_hsv
);

    logic            f_vld, f_rdy, q_vld, q_rdy;
    rhsv_pkg::t_work f_work, q_work;

    // Classification and operand forming.
    rhsv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (i_pix),
        .o_vld   (f_vld),
        .o_work  (f_work),
        .i_rdy   (f_rdy)
    );

    // Decoupling queue.
    rhsv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (f_vld),
        .i_work  (f_work),
        .o_rdy   (f_rdy),
        .o_vld   (q_vld),
        .o_work  (q_work),
        .i_rdy   (q_rdy)
    );

    // Divider pipeline.
    rhsv_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (q_vld),
        .i_work  (q_work),
        .o_rdy   (q_rdy),
        .o_hsv   (o_hsv)
    );

endmodule

// ===== hdl/rhsv_front.sv =====
// Front end: accepts a pixel, finds max, min and sector, and forms the
// dividends and divisors. Depends on rhsv_pkg and rhsv_rgb_if.
`timescale 1ns / 1ps

module rhsv_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    rhsv_rgb_if.sink            i_pix,
    output logic                o_vld,
    output rhsv_pkg::t_work     o_work,
    input  logic                i_rdy
);

    logic [rhsv_pkg::CompW-1:0] mx, mn, dl;
    logic [rhsv_pkg::DenW-1:0]  hnum;
    rhsv_pkg::t_work            n_work;
    rhsv_pkg::t_work            r_work;
    logic                       r_vld;

    // Sector selection and numerator forming.
    always_comb begin
        logic [rhsv_pkg::CompW-1:0] r, g, b;
        r  = i_pix.red;
        g  = i_pix.green;
        b  = i_pix.blue;
        mx = (r > g) ? r : g;
        mx = (mx > b) ? mx : b;
        mn = (r < g) ? r : g;
        mn = (mn < b) ? mn : b;
        dl = mx - mn;
        if (mx == r) begin
            if (g >= b) hnum = rhsv_pkg::DenW'(g - b);
            else        hnum = rhsv_pkg::DenW'(6) * rhsv_pkg::DenW'(dl)
                               - rhsv_pkg::DenW'(b - g);
        end else if (mx == g) begin
            hnum = rhsv_pkg::DenW'(2) * rhsv_pkg::DenW'(dl)
                   + rhsv_pkg::DenW'(b) - rhsv_pkg::DenW'(r);
        end else begin
            hnum = rhsv_pkg::DenW'(4) * rhsv_pkg::DenW'(dl)
                   + rhsv_pkg::DenW'(r) - rhsv_pkg::DenW'(g);
        end

        // Times 255 as a shift and a subtract; a zero divisor becomes one
        // over a zero dividend, so gray and black give zero.
        n_work.value   = mx;
        n_work.hue.quo = '0;
        n_work.sat.quo = '0;
        if (dl == '0) begin
            n_work.hue.rem = '0;
            n_work.hue.den = rhsv_pkg::DenW'(1);
        end else begin
            n_work.hue.rem = (rhsv_pkg::NumW'(hnum) << 8) - rhsv_pkg::NumW'(hnum);
            n_work.hue.den = rhsv_pkg::DenW'(6) * rhsv_pkg::DenW'(dl);
        end
        if (mx == '0) begin
            n_work.sat.rem = '0;
            n_work.sat.den = rhsv_pkg::DenW'(1);
        end else begin
            n_work.sat.rem = (rhsv_pkg::NumW'(dl) << 8) - rhsv_pkg::NumW'(dl);
            n_work.sat.den = rhsv_pkg::DenW'(mx);
        end
    end

    assign i_pix.ready = !r_vld || i_rdy;

    // Output register toward the queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_pix.ready) begin
            r_vld <= i_pix.valid;
        end
        if (i_pix.valid && i_pix.ready) begin
            r_work <= n_work;
        end
    end

    assign o_vld  = r_vld;
    assign o_work = r_work;

endmodule

// ===== hdl/rhsv_queue.sv =====
// Two-entry queue that decouples the front end from the divider pipeline.
// Depends on rhsv_pkg.
`timescale 1ns / 1ps

module rhsv_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    input  rhsv_pkg::t_work     i_work,
    output logic                o_rdy,
    output logic                o_vld,
    output rhsv_pkg::t_work     o_work,
    input  logic                i_rdy
);

    rhsv_pkg::t_work r_mem [rhsv_pkg::QDepth];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    logic            wr, rd;

    assign o_rdy  = (r_cnt != 2'(rhsv_pkg::QDepth));
    assign o_vld  = (r_cnt != '0);
    assign o_work = r_mem[r_rp];
    assign wr     = i_vld && o_rdy;
    assign rd     = o_vld && i_rdy;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= !r_wp;
            if (rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_work;
    end

endmodule

// ===== hdl/rhsv_back.sv =====
// Back end: two eight-stage restoring dividers, one quotient bit a stage.
// Depends on rhsv_pkg and rhsv_hsv_if.
`timescale 1ns / 1ps

module rhsv_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    input  rhsv_pkg::t_work     i_work,
    output logic                o_rdy,
    rhsv_hsv_if.source          o_hsv
);

    localparam int unsigned Last = rhsv_pkg::QuotW - 1;

    rhsv_pkg::t_work r_st  [rhsv_pkg::QuotW];
    logic            r_vld [rhsv_pkg::QuotW];
    logic            en;

    // The whole pipeline moves unless the last stage holds an untaken result.
    assign en    = !r_vld[Last] || o_hsv.ready;
    assign o_rdy = en;

    // Stage k settles quotient bit Last-k of both divisions.
    for (genvar k = 0; k < rhsv_pkg::QuotW; k++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (en) begin
                if (k == 0) r_vld[k] <= i_vld;
                else        r_vld[k] <= r_vld[(k == 0) ? 0 : k-1];
            end
            if (en) begin
                if (k == 0) begin
                    r_st[k].hue   <= rhsv_pkg::div_step(i_work.hue, Last - k);
                    r_st[k].sat   <= rhsv_pkg::div_step(i_work.sat, Last - k);
                    r_st[k].value <= i_work.value;
                end else begin
                    r_st[k].hue   <= rhsv_pkg::div_step(r_st[(k == 0) ? 0 : k-1].hue,
                                                        Last - k);
                    r_st[k].sat   <= rhsv_pkg::div_step(r_st[(k == 0) ? 0 : k-1].sat,
                                                        Last - k);
                    r_st[k].value <= r_st[(k == 0) ? 0 : k-1].value;
                end
            end
        end
    end

    assign o_hsv.valid      = r_vld[Last];
    assign o_hsv.hue        = r_st[Last].hue.quo;
    assign o_hsv.saturation = r_st[Last].sat.quo;
    assign o_hsv.brightness = r_st[Last].value;

endmodule

// ===== tb/sv/rgb_to_hsv_convert_tb.sv =====
// Testbench for rgb_to_hsv_convert: drives RGB requests, predicts HSV results.
// Depends on rhsv_pkg, the channel interfaces and the converter RTL.
`timescale 1ns / 1ps

// Holds expected HSV results in request order and checks each one that arrives.
class hsv_scoreboard;
    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] sat;
        logic [7:0] val;
    } hsv_t;

    hsv_t pending[$];
    int   errors = 0;

    // Compute the HSV triple of one pixel and queue it.
    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        hsv_t        e;
        int unsigned mx, mn, spread, num;
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        spread = mx - mn;
        e.val = mx[7:0];
        e.sat = (mx != 0) ? 8'((255 * spread) / mx) : 8'd0;
        e.hue = 8'd0;
        if (spread != 0) begin
            // Sector goes to red first, then green, then blue.
            if (mx == r)
                num = (g >= b) ? (g - b) : (6 * spread - (b - g));
            else if (mx == g)
                num = 2 * spread + b - r;
            else
                num = 4 * spread + r - g;
            e.hue = 8'((255 * num) / (6 * spread));
        end
        pending.push_back(e);
    endfunction

    // Compare one accepted result with the oldest expectation.
    function void check_result(logic [7:0] h, logic [7:0] s, logic [7:0] v);
        hsv_t e;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected result h=%0d s=%0d v=%0d", h, s, v);
            return;
        end
        e = pending.pop_front();
        if (h !== e.hue || s !== e.sat || v !== e.val) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: expected h=%0d s=%0d v=%0d, got h=%0d s=%0d v=%0d",
                         e.hue, e.sat, e.val, h, s, v);
        end
    endfunction
endclass

module rgb_to_hsv_convert_tb;

    localparam int CycleLimit = 200000;

    logic i_clk;
    logic i_rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   cycle_count = 0;

    rhsv_rgb_if pix_ch();
    rhsv_hsv_if hsv_ch();

    hsv_scoreboard hsv_sb;

    rgb_to_hsv_convert u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .o_hsv   (hsv_ch)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Cycle limit guards against a hang.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("rgb_to_hsv_convert_tb: errors");
            $finish;
        end
    end

    // Result side: random stalls, check every accepted result.
    always @(posedge i_clk) begin
        if (i_rst_n && hsv_ch.valid && hsv_ch.ready)
            hsv_sb.check_result(hsv_ch.hue, hsv_ch.saturation, hsv_ch.brightness);
        hsv_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Send one pixel request, idling at random first, and wait for acceptance.
    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            pix_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.red   <= r;
        pix_ch.green <= g;
        pix_ch.blue  <= b;
        @(posedge i_clk);
        while (!pix_ch.ready) @(posedge i_clk);
        hsv_sb.note_pixel(r, g, b);
    endtask

    // Random pixel, uniform half the time, else with ties or gray.
    task automatic send_random_pixel();
        logic [7:0] r, g, b;
        r = 8'($urandom_range(255));
        g = 8'($urandom_range(255));
        b = 8'($urandom_range(255));
        case ($urandom_range(7))
            0: g = r;
            1: b = g;
            2: b = r;
            3: begin g = r; b = r; end
            default: ;
        endcase
        send_pixel(r, g, b);
    endtask

    initial begin
        hsv_sb         = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pix_ch.valid   = 1'b0;
        pix_ch.red     = '0;
        pix_ch.green   = '0;
        pix_ch.blue    = '0;
        hsv_ch.ready   = 1'b0;
        i_rst_n        = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: black, white, gray, primaries, ties and the red wrap.
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd1,   8'd1,   8'd1);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd255);
        send_pixel(8'd255, 8'd0,   8'd1);
        send_pixel(8'd255, 8'd1,   8'd0);
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'd0,   8'd1,   8'd0);
        send_pixel(8'd0,   8'd0,   8'd1);
        send_pixel(8'd255, 8'd254, 8'd254);
        send_pixel(8'd170, 8'd85,  8'd255);
        send_pixel(8'd200, 8'd100, 8'd50);

        // Random part in four phases of sender idling and receiver stalls.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            for (int n = 0; n < 110; n++) send_random_pixel();
        end
        pix_ch.valid   <= 1'b0;
        recv_stall_pct = 0;

        while (hsv_sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (hsv_sb.errors == 0)
            $display("rgb_to_hsv_convert_tb: clean");
        else
            $display("rgb_to_hsv_convert_tb: errors");
        $finish;
    end
endmodule
